### hdl/gsdc_pkg.sv
`timescale 1ns / 1ps
package gsdc_pkg;

  localparam int NUM_AXES   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_RADIUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECENTRE_BUTTON = 2'd2;

  localparam logic [6:0]  DEAD_RADIUS_RST     = 7'd25;
  localparam logic [7:0]  MAX_RADIUS_RST      = 8'd120;
  localparam logic [3:0]  RECENTRE_BUTTON_RST = 4'd2;

  localparam logic [3:0]  MODE_STANDARD = 4'd4;
  localparam logic [3:0]  MODE_ANALOG   = 4'd7;
  localparam logic [15:0] BUTTON_INVERT = 16'hffff;
  localparam logic [15:0] FULL_SCALE    = 16'd16384;

  localparam int QUO_BITS   = 16;
  localparam int STEP_BITS  = 2;
  localparam int DIV_CYCLES = QUO_BITS / STEP_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic [15:0] raw_buttons;
    logic [3:0]  mode_id;
    logic [7:0]  left_horiz;
    logic [7:0]  left_vert;
    logic [7:0]  right_horiz;
    logic [7:0]  right_vert;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        buttons_now;
    logic [15:0]        press_edges;
    logic signed [15:0] left_x_pos;
    logic signed [15:0] left_y_pos;
    logic signed [15:0] right_x_pos;
    logic signed [15:0] right_y_pos;
    logic               left_changed;
    logic               right_changed;
  } out_word_t;

  typedef struct packed {
    logic [7:0] val;
    logic [7:0] centre;
    logic [7:0] prev;
    logic       negate;
  } lane_op_t;

  typedef struct packed {
    logic [6:0] dead_radius;
    logic [7:0] max_radius;
  } lane_cfg_t;

  typedef struct packed {
    logic signed [15:0] pos;
    logic               chg;
  } lane_res_t;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_PREP,
    LN_DIV,
    LN_FIN
  } lane_st_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_HOLD
  } ctl_st_t;

endpackage

### hdl/gsdc_lane.sv
`timescale 1ns / 1ps
module gsdc_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  gsdc_pkg::lane_op_t  op,
  input  gsdc_pkg::lane_cfg_t cfg,
  output logic                done,
  output gsdc_pkg::lane_res_t res
);
  import gsdc_pkg::*;

  lane_st_t st_r, st_nxt;
  lane_op_t op_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic        sgn_r, outside_r, chg_r, ovf_r, done_r;
  logic [8:0]  den_r, rem_r;
  logic [15:0] dvd_r, quo_r;
  lane_res_t   res_r;

  logic [8:0]  d, pd;
  logic [7:0]  ad, apd, dz, mag, div;
  logic        outside, reentry;
  logic [8:0]  den;
  logic [9:0]  r_a, r_b;
  logic        ge_a, ge_b;
  logic [8:0]  r_a2, r_b2;
  logic [15:0] q_clamp;

  always_comb begin
    d       = {1'b0, op_r.val} - {1'b0, op_r.centre};
    pd      = {1'b0, op_r.prev} - {1'b0, op_r.centre};
    ad      = d[8] ? 8'(~d + 9'd1) : d[7:0];
    apd     = pd[8] ? 8'(~pd + 9'd1) : pd[7:0];
    dz      = {1'b0, cfg.dead_radius};
    outside = ad > dz;
    reentry = apd > dz;
    mag     = ad - dz;
    div     = (cfg.max_radius == 8'd0) ? 8'd1 : cfg.max_radius;
    den     = {div, 1'b0};

    r_a  = {rem_r, dvd_r[15]};
    ge_a = r_a >= {1'b0, den_r};
    r_a2 = ge_a ? 9'(r_a - {1'b0, den_r}) : r_a[8:0];
    r_b  = {r_a2, dvd_r[14]};
    ge_b = r_b >= {1'b0, den_r};
    r_b2 = ge_b ? 9'(r_b - {1'b0, den_r}) : r_b[8:0];

    q_clamp = (ovf_r || quo_r > FULL_SCALE) ? FULL_SCALE : quo_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      LN_IDLE: if (start) st_nxt = LN_PREP;
      LN_PREP: st_nxt = LN_DIV;
      LN_DIV:  if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) st_nxt = LN_FIN;
      LN_FIN:  st_nxt = LN_IDLE;
      default: st_nxt = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= LN_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      case (st_r)
        LN_IDLE: begin
          if (start) op_r <= op;
        end
        LN_PREP: begin
          sgn_r     <= d[8] ^ op_r.negate;
          outside_r <= outside;
          chg_r     <= outside | reentry;
          den_r     <= den;
          ovf_r     <= {2'b00, mag[7:1]} >= den;
          rem_r     <= {2'b00, mag[7:1]};
          dvd_r     <= {mag[0], 7'd0, div};
          quo_r     <= '0;
          cnt_r     <= '0;
        end
        LN_DIV: begin
          rem_r <= r_b2;
          dvd_r <= {dvd_r[13:0], 2'b00};
          quo_r <= {quo_r[13:0], ge_a, ge_b};
          cnt_r <= cnt_r + DIV_CNT_W'(1);
        end
        LN_FIN: begin
          res_r.chg <= chg_r;
          if (!outside_r) res_r.pos <= '0;
          else if (sgn_r) res_r.pos <= -$signed(q_clamp);
          else res_r.pos <= $signed(q_clamp);
          done_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### hdl/gamepad_stick_deadzone_conditioner_core.sv
`timescale 1ns / 1ps
// Each word passes through accept, one lane set-up, 8 divider steps of
// 2 quotient bits, lane finish and merge; in_ready returns in the cycle after merge,
// so the next word is accepted only after the last one has merged.
// A word in the output register does not block the next accept; a second
// finished word holds in_ready low until the register frees.
// Reset (synchronous, rst_n low): dead radius 25, max radius 120, recentre button 2,
// control cleared, no buttons held, both sticks uncentred.
module gamepad_stick_deadzone_conditioner_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gsdc_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gsdc_pkg::out_word_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [gsdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gsdc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gsdc_pkg::*;

  ctl_st_t st_r, st_nxt;

  logic [6:0]  dead_radius_r;
  logic [7:0]  max_radius_r;
  logic [3:0]  recentre_r;
  logic [15:0] prev_buttons_r;
  logic        left_centred_r, right_centred_r;
  logic [7:0]  centre_r [NUM_AXES];
  logic [7:0]  prev_axes_r [NUM_AXES];

  logic [15:0] btn_r, edges_r;
  logic [1:0]  fresh_r;
  logic        out_valid_r;
  out_word_t   out_r;

  logic [7:0]  cur [NUM_AXES];
  logic [15:0] btn, edges;
  logic        recentre;
  logic [1:0]  fresh;
  logic        in_fire, out_free, load_out;
  lane_cfg_t   lcfg;
  lane_op_t    lop [NUM_AXES];
  lane_res_t   lres [NUM_AXES];
  logic [NUM_AXES-1:0] lane_done;
  logic        all_done;
  out_word_t   out_nxt;

  always_comb begin
    cur[0]   = in_data.left_horiz;
    cur[1]   = in_data.left_vert;
    cur[2]   = in_data.right_horiz;
    cur[3]   = in_data.right_vert;
    btn      = (in_data.mode_id == MODE_STANDARD || in_data.mode_id == MODE_ANALOG)
               ? (in_data.raw_buttons ^ BUTTON_INVERT) : in_data.raw_buttons;
    edges    = btn & ~prev_buttons_r;
    recentre = edges[recentre_r];
    fresh    = {recentre | ~right_centred_r, recentre | ~left_centred_r};
    in_fire  = in_valid & in_ready;
    out_free = !out_valid_r || out_ready;
    all_done = &lane_done;
    lcfg.dead_radius = dead_radius_r;
    lcfg.max_radius  = max_radius_r;
  end

  genvar g;
  generate
    for (g = 0; g < NUM_AXES; g++) begin : g_lane
      localparam int STICK = g / 2;

      always_comb begin
        lop[g].val    = cur[g];
        lop[g].centre = centre_r[g];
        lop[g].prev   = prev_axes_r[g];
        lop[g].negate = 1'(g % 2);
      end

      always_ff @(posedge clk) begin
        if (in_fire) begin
          prev_axes_r[g] <= cur[g];
          if (fresh[STICK]) centre_r[g] <= cur[g];
        end
      end

      gsdc_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire),
        .op    (lop[g]),
        .cfg   (lcfg),
        .done  (lane_done[g]),
        .res   (lres[g])
      );
    end
  endgenerate

  always_comb begin
    st_nxt   = st_r;
    load_out = 1'b0;
    unique case (st_r)
      ST_IDLE: if (in_fire) st_nxt = ST_BUSY;
      ST_BUSY: begin
        if (all_done) begin
          if (out_free) begin
            load_out = 1'b1;
            st_nxt   = ST_IDLE;
          end else begin
            st_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // merge the lanes; an uncentred or recentring stick reports zero and a change
  always_comb begin
    out_nxt.buttons_now   = btn_r;
    out_nxt.press_edges   = edges_r;
    out_nxt.left_x_pos    = fresh_r[0] ? '0 : lres[0].pos;
    out_nxt.left_y_pos    = fresh_r[0] ? '0 : lres[1].pos;
    out_nxt.right_x_pos   = fresh_r[1] ? '0 : lres[2].pos;
    out_nxt.right_y_pos   = fresh_r[1] ? '0 : lres[3].pos;
    out_nxt.left_changed  = fresh_r[0] | lres[0].chg | lres[1].chg;
    out_nxt.right_changed = fresh_r[1] | lres[2].chg | lres[3].chg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r            <= ST_IDLE;
      out_valid_r     <= 1'b0;
      dead_radius_r   <= DEAD_RADIUS_RST;
      max_radius_r    <= MAX_RADIUS_RST;
      recentre_r      <= RECENTRE_BUTTON_RST;
      prev_buttons_r  <= '0;
      left_centred_r  <= 1'b0;
      right_centred_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_DEAD_RADIUS:     dead_radius_r <= cfg_wdata[6:0];
          CFG_MAX_RADIUS:      max_radius_r  <= cfg_wdata[7:0];
          CFG_RECENTRE_BUTTON: recentre_r    <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        prev_buttons_r  <= btn;
        left_centred_r  <= 1'b1;
        right_centred_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      btn_r   <= btn;
      edges_r <= edges;
      fresh_r <= fresh;
    end
    if (load_out) out_r <= out_nxt;
  end

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
